// ===== hw/rtl/irom_pkg.sv =====
// ----------------------------------------------------------------------------
// irom_pkg - shared types and constants of the integer to Roman converter
// Holds field widths, the ASCII codes of the symbols and the pattern of
// symbols that one decimal digit turns into.
// ----------------------------------------------------------------------------
package irom_pkg;

  localparam int VALUE_W = 12;
  localparam int SYM_W   = 7;
  localparam int DIGITS  = 4;   // thousands, hundreds, tens, units
  localparam int SLOTS   = 4;   // most symbols one digit can produce

  localparam logic [SYM_W-1:0] SYM_I = 7'h49;
  localparam logic [SYM_W-1:0] SYM_V = 7'h56;
  localparam logic [SYM_W-1:0] SYM_X = 7'h58;
  localparam logic [SYM_W-1:0] SYM_L = 7'h4C;
  localparam logic [SYM_W-1:0] SYM_C = 7'h43;
  localparam logic [SYM_W-1:0] SYM_D = 7'h44;
  localparam logic [SYM_W-1:0] SYM_M = 7'h4D;

  // Decimal digits of one value; the thousands digit reaches 4 above 3999.
  typedef struct packed {
    logic [2:0] th;
    logic [3:0] hu;
    logic [3:0] te;
    logic [3:0] on;
  } digits_t;

  // Symbols of one digit, slot 0 first, and how many of them are used.
  typedef struct packed {
    logic [2:0]                  len;
    logic [SLOTS-1:0][SYM_W-1:0] sym;
  } digit_pat_t;

  // A whole numeral as four digit patterns, thousands in entry 0.
  typedef struct packed {
    digit_pat_t [DIGITS-1:0] dig;
    logic [1:0]              first_idx;
    logic [1:0]              last_idx;
    logic                    nonempty;
  } numeral_t;

  // Standard encoding of a digit 0..9 with the subtractive forms for 4 and 9.
  function automatic digit_pat_t digit_pattern(input logic [3:0] d,
                                               input logic [SYM_W-1:0] one,
                                               input logic [SYM_W-1:0] five,
                                               input logic [SYM_W-1:0] ten);
    digit_pat_t p;
    p.len = 3'd0;
    p.sym = {SLOTS{one}};
    case (d)
      4'd1, 4'd2, 4'd3: begin
        p.len = d[2:0];
      end
      4'd4: begin
        p.len    = 3'd2;
        p.sym[1] = five;
      end
      4'd5, 4'd6, 4'd7, 4'd8: begin
        // The five symbol followed by d - 5 ones, so d - 4 symbols in all.
        p.len    = 3'(d - 4'd4);
        p.sym[0] = five;
      end
      4'd9: begin
        p.len    = 3'd2;
        p.sym[1] = ten;
      end
      default: begin
        p.len = 3'd0;
      end
    endcase
    return p;
  endfunction

endpackage

// ===== hw/rtl/irom_ifs.sv =====
// ----------------------------------------------------------------------------
// irom_ifs - request and result channels of the integer to Roman converter
// Valid/ready channels; a transfer happens when both are high at a clock edge.
// ----------------------------------------------------------------------------
interface irom_req_if
  import irom_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;

  modport source(output valid, output value, input ready);
  modport sink(input valid, input value, output ready);
endinterface

interface irom_rsp_if
  import irom_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] symbol;
  logic             last;

  modport source(output valid, output symbol, output last, input ready);
  modport sink(input valid, input symbol, input last, output ready);
endinterface

// ===== hw/rtl/irom_split.sv =====
// ----------------------------------------------------------------------------
// irom_split - three stage decimal digit split
// Peels off thousands, then hundreds, then tens and units, one per stage.
// ----------------------------------------------------------------------------
module irom_split
  import irom_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [VALUE_W-1:0] in_value,
  output logic               out_valid,
  input  logic               out_ready,
  output digits_t            out_digits
);

  logic         v1, v2, v3;
  logic [2:0]   th1, th2, th3;
  logic [9:0]   r1;
  logic [3:0]   hu2, hu3;
  logic [6:0]   r2;
  logic [3:0]   te3, on3;
  logic         adv1, adv2, adv3;

  logic [2:0]         th_c;
  logic [VALUE_W-1:0] th_sub;
  logic [VALUE_W-1:0] rem_c;
  logic [3:0]         hu_c;
  logic [9:0]         hu_sub;
  logic [9:0]         rem2_c;
  logic [14:0]        prod_c;
  logic [3:0]         te_c;
  logic [6:0]         on_c;

  assign adv3     = !v3 || out_ready;
  assign adv2     = !v2 || adv3;
  assign adv1     = !v1 || adv2;
  assign in_ready = adv1;

  always_comb begin
    th_c = 3'd0;
    for (int k = 1; k <= 4; k++) begin
      if (in_value >= VALUE_W'(k * 1000)) th_c = 3'(k);
    end
    th_sub = VALUE_W'(th_c) * VALUE_W'(1000);
    rem_c  = in_value - th_sub;
  end

  always_comb begin
    hu_c = 4'd0;
    for (int k = 1; k <= 9; k++) begin
      if (r1 >= 10'(k * 100)) hu_c = 4'(k);
    end
    hu_sub = 10'(hu_c) * 10'd100;
    rem2_c = r1 - hu_sub;
  end

  // Quotient by ten through the reciprocal 205/2048, exact below 160.
  always_comb begin
    prod_c = 15'(r2) * 15'd205;
    te_c   = prod_c[14:11];
    on_c   = r2 - 7'(te_c) * 7'd10;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (adv1) v1 <= in_valid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
    end
    if (adv1) begin
      th1 <= th_c;
      r1  <= rem_c[9:0];
    end
    if (adv2) begin
      th2 <= th1;
      hu2 <= hu_c;
      r2  <= rem2_c[6:0];
    end
    if (adv3) begin
      th3 <= th2;
      hu3 <= hu2;
      te3 <= te_c;
      on3 <= on_c[3:0];
    end
  end

  assign out_valid     = v3;
  assign out_digits.th = th3;
  assign out_digits.hu = hu3;
  assign out_digits.te = te3;
  assign out_digits.on = on3;

endmodule

// ===== hw/rtl/irom_encode.sv =====
// ----------------------------------------------------------------------------
// irom_encode - digit to symbol pattern stage
// Turns four decimal digits into their symbol patterns and marks the first
// and last digit that produce any symbol.
// ----------------------------------------------------------------------------
module irom_encode
  import irom_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  digits_t  in_digits,
  output logic     out_valid,
  input  logic     out_ready,
  output numeral_t out_numeral
);

  logic     v4;
  numeral_t num;
  numeral_t num_next;
  logic     adv4;

  assign adv4     = !v4 || out_ready;
  assign in_ready = adv4;

  always_comb begin
    num_next.dig[0].len = in_digits.th;
    num_next.dig[0].sym = {SLOTS{SYM_M}};
    num_next.dig[1]     = digit_pattern(in_digits.hu, SYM_C, SYM_D, SYM_M);
    num_next.dig[2]     = digit_pattern(in_digits.te, SYM_X, SYM_L, SYM_C);
    num_next.dig[3]     = digit_pattern(in_digits.on, SYM_I, SYM_V, SYM_X);
    num_next.first_idx  = 2'd0;
    num_next.last_idx   = 2'd0;
    num_next.nonempty   = 1'b0;
    for (int k = DIGITS - 1; k >= 0; k--) begin
      if (num_next.dig[k].len != 3'd0) num_next.first_idx = 2'(k);
    end
    for (int k = 0; k < DIGITS; k++) begin
      if (num_next.dig[k].len != 3'd0) begin
        num_next.last_idx = 2'(k);
        num_next.nonempty = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (adv4) begin
      v4 <= in_valid;
    end
    if (adv4) num <= num_next;
  end

  assign out_valid   = v4;
  assign out_numeral = num;

endmodule

// ===== hw/rtl/irom_emit.sv =====
// ----------------------------------------------------------------------------
// irom_emit - symbol sequencer
// Steps through the stored digit patterns and hands out one symbol a cycle while out_ready is high.
// ----------------------------------------------------------------------------
module irom_emit
  import irom_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  numeral_t         in_numeral,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [SYM_W-1:0] out_symbol,
  output logic             out_last
);

  logic       busy;
  numeral_t   num;
  logic [1:0] idx;
  logic [1:0] pos;

  logic       fire;
  logic       digit_end;
  logic       at_end;
  logic [1:0] next_idx;
  digit_pat_t cur;

  assign cur       = num.dig[idx];
  assign fire      = busy && out_ready;
  assign digit_end = (3'(pos) == cur.len - 3'd1);
  assign at_end    = digit_end && (idx == num.last_idx);
  assign in_ready  = !busy || (fire && at_end);

  // Next digit after the current one that has any symbols.
  always_comb begin
    next_idx = idx;
    for (int k = DIGITS - 1; k >= 0; k--) begin
      if (2'(k) > idx && num.dig[k].len != 3'd0) next_idx = 2'(k);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (in_ready) begin
      busy <= in_valid && in_numeral.nonempty;
    end
    if (in_ready) begin
      num <= in_numeral;
      idx <= in_numeral.first_idx;
      pos <= 2'd0;
    end else if (fire) begin
      if (digit_end) begin
        idx <= next_idx;
        pos <= 2'd0;
      end else begin
        pos <= pos + 2'd1;
      end
    end
  end

  assign out_valid  = busy;
  assign out_symbol = cur.sym[pos];
  assign out_last   = at_end;

endmodule

// ===== hw/rtl/integer_to_roman.sv =====
// ----------------------------------------------------------------------------
// integer_to_roman - integer to Roman numeral converter
// Converts each request value into its Roman numeral, emitted as ASCII
// symbols most significant first, with the final symbol flagged.
// ----------------------------------------------------------------------------
//
//   channel  direction  payload                 transfer
//   req      in         value[11:0]             req.valid && req.ready
//   rsp      out        symbol[6:0], last       rsp.valid && rsp.ready
//
// A request passes four register stages (thousands split, hundreds split,
// tens and units split, symbol pattern encode) and the sequencer register
// before its first symbol shows. The sequencer then sends its n symbols,
// n up to 15, one each cycle that rsp is ready, and so sets the rate.
// A value of zero produces no symbols and never makes the sequencer busy.
// Reset is synchronous and clears only the valid and busy flags. A stall on
// rsp backs up stage by stage; nothing is dropped or sent twice.
//
module integer_to_roman
  import irom_pkg::*;
(
  input logic      clk,
  input logic      rst,
  irom_req_if.sink   req,
  irom_rsp_if.source rsp
);

  // Digit split pipeline to encoder.
  logic     split_valid;
  logic     split_ready;
  digits_t  split_digits;

  // Encoder to symbol sequencer.
  logic     enc_valid;
  logic     enc_ready;
  numeral_t enc_numeral;

  irom_split u_split (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (req.valid),
    .in_ready   (req.ready),
    .in_value   (req.value),
    .out_valid  (split_valid),
    .out_ready  (split_ready),
    .out_digits (split_digits)
  );

  irom_encode u_encode (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (split_valid),
    .in_ready    (split_ready),
    .in_digits   (split_digits),
    .out_valid   (enc_valid),
    .out_ready   (enc_ready),
    .out_numeral (enc_numeral)
  );

  // The sequencer takes the next request in the same cycle that the last
  // symbol of the current one is accepted, so runs follow without a gap.
  irom_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (enc_valid),
    .in_ready   (enc_ready),
    .in_numeral (enc_numeral),
    .out_valid  (rsp.valid),
    .out_ready  (rsp.ready),
    .out_symbol (rsp.symbol),
    .out_last   (rsp.last)
  );

endmodule
